@@ design/lsmt_pkg.sv @@
package lsmt_pkg;

    typedef enum logic [1:0] {
        MODE_HBLANK = 2'd0,
        MODE_VBLANK = 2'd1,
        MODE_SCAN   = 2'd2,
        MODE_DRAW   = 2'd3
    } mode_t;

    localparam int ACC_W  = 10;
    localparam int LINE_W = 8;
    localparam int EN_W   = 4;
    localparam int CYC_W  = 8;
    localparam int CFG_DATA_W = 8;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_COMPARE_LINE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_STAT_ENABLES = 1'd1;

    localparam int EN_COMPARE_BIT = 0;
    localparam int EN_HBLANK_BIT  = 1;
    localparam int EN_VBLANK_BIT  = 2;
    localparam int EN_SCAN_BIT    = 3;

    localparam logic [ACC_W-1:0] SCAN_LEN   = 10'd80;
    localparam logic [ACC_W-1:0] DRAW_LEN   = 10'd172;
    localparam logic [ACC_W-1:0] HBLANK_LEN = 10'd204;
    localparam logic [ACC_W-1:0] LINE_LEN   = 10'd456;
    localparam logic [ACC_W-1:0] LINE_LEN_X2 = 10'd912;

    localparam logic [LINE_W-1:0] FIRST_VBLANK_LINE = 8'd144;
    localparam logic [LINE_W-1:0] LAST_LINE         = 8'd153;

    // Reciprocal factors: q_est = (x * RECIP) >> SHIFT, never above x / LEN
    // and at most one below it over the accumulator range.
    localparam logic [15:0] SCAN_RECIP    = 16'd51;
    localparam int          SCAN_SHIFT    = 12;
    localparam logic [12:0] HBLANK_RECIP  = 13'd5;
    localparam int          HBLANK_SHIFT  = 10;

    typedef struct packed {
        logic [LINE_W-1:0] compare_line;
        logic [EN_W-1:0]   stat_irq_enables;
    } cfg_t;

    typedef struct packed {
        logic [1:0]        mode_now;
        logic [LINE_W-1:0] line_now;
        logic              coincidence;
        logic              stat_irq;
        logic              vblank_irq;
        logic              render_line;
        logic [LINE_W-1:0] render_line_index;
    } result_t;

    function automatic logic [ACC_W-1:0] mod_scan(input logic [ACC_W-1:0] x);
        logic [15:0]      prod;
        logic [3:0]       q;
        logic [ACC_W-1:0] r;
        prod = 16'(x) * SCAN_RECIP;
        q    = prod[SCAN_SHIFT +: 4];
        r    = x - ACC_W'(10'(q) * SCAN_LEN);
        if (r >= SCAN_LEN)
        begin
            r = r - SCAN_LEN;
        end
        return r;
    endfunction

    function automatic logic [ACC_W-1:0] mod_hblank(input logic [ACC_W-1:0] x);
        logic [12:0]      prod;
        logic [2:0]       q;
        logic [ACC_W-1:0] r;
        prod = 13'(x) * HBLANK_RECIP;
        q    = prod[HBLANK_SHIFT +: 3];
        r    = x - ACC_W'(10'(q) * HBLANK_LEN);
        if (r >= HBLANK_LEN)
        begin
            r = r - HBLANK_LEN;
        end
        return r;
    endfunction

    function automatic logic [ACC_W-1:0] mod_line(input logic [ACC_W-1:0] x);
        logic [ACC_W-1:0] r;
        if (x >= LINE_LEN_X2)
        begin
            r = x - LINE_LEN_X2;
        end
        else if (x >= LINE_LEN)
        begin
            r = x - LINE_LEN;
        end
        else
        begin
            r = x;
        end
        return r;
    endfunction

endpackage

@@ design/lsmt_if.sv @@
interface lsmt_in_if;
    import lsmt_pkg::*;

    logic             valid;
    logic             ready;
    logic [CYC_W-1:0] elapsed_cycles;

    modport source (output valid, output elapsed_cycles, input ready);
    modport sink   (input valid, input elapsed_cycles, output ready);
endinterface

interface lsmt_out_if;
    import lsmt_pkg::*;

    logic              valid;
    logic              ready;
    logic [1:0]        mode_now;
    logic [LINE_W-1:0] line_now;
    logic              coincidence;
    logic              stat_irq;
    logic              vblank_irq;
    logic              render_line;
    logic [LINE_W-1:0] render_line_index;

    modport source (output valid, output mode_now, output line_now, output coincidence,
                    output stat_irq, output vblank_irq, output render_line,
                    output render_line_index, input ready);
    modport sink   (input valid, input mode_now, input line_now, input coincidence,
                    input stat_irq, input vblank_irq, input render_line,
                    input render_line_index, output ready);
endinterface

@@ design/lsmt_cfg_regs.sv @@
module lsmt_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [lsmt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lsmt_pkg::CFG_DATA_W-1:0]  cfg_data,
    output lsmt_pkg::cfg_t                   cfg
);
    import lsmt_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_IDX_COMPARE_LINE: cfg_next.compare_line = cfg_data[LINE_W-1:0];
                CFG_IDX_STAT_ENABLES: cfg_next.stat_irq_enables = cfg_data[EN_W-1:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;
endmodule

@@ design/lsmt_seq.sv @@
module lsmt_seq (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         step,
    input  logic [lsmt_pkg::CYC_W-1:0]   elapsed_cycles,
    input  lsmt_pkg::cfg_t               cfg,
    output lsmt_pkg::result_t            result
);
    import lsmt_pkg::*;

    mode_t             mode_reg, mode_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [LINE_W-1:0] line_reg, line_next;
    logic              coin_reg, coin_next;
    logic [ACC_W-1:0]  sum;
    logic              stat;
    logic              vbl;
    logic              render;
    logic [LINE_W-1:0] render_idx;

    assign sum = acc_reg + ACC_W'(elapsed_cycles);

    always_comb
    begin
        mode_next  = mode_reg;
        acc_next   = sum;
        line_next  = line_reg;
        coin_next  = coin_reg;
        stat       = 1'b0;
        vbl        = 1'b0;
        render     = 1'b0;
        render_idx = '0;
        case (mode_reg)
            MODE_SCAN:
            begin
                if (sum >= SCAN_LEN)
                begin
                    acc_next  = mod_scan(sum);
                    coin_next = (line_reg == cfg.compare_line);
                    stat      = coin_next && cfg.stat_irq_enables[EN_COMPARE_BIT];
                    mode_next = MODE_DRAW;
                end
            end
            MODE_DRAW:
            begin
                if (sum >= DRAW_LEN)
                begin
                    acc_next   = sum - DRAW_LEN;
                    render     = 1'b1;
                    render_idx = line_reg;
                    mode_next  = MODE_HBLANK;
                    stat       = cfg.stat_irq_enables[EN_HBLANK_BIT];
                end
            end
            MODE_HBLANK:
            begin
                if (sum >= HBLANK_LEN)
                begin
                    acc_next  = mod_hblank(sum);
                    line_next = line_reg + 8'd1;
                    coin_next = (line_next == cfg.compare_line);
                    stat      = coin_next && cfg.stat_irq_enables[EN_COMPARE_BIT];
                    if (line_next == FIRST_VBLANK_LINE)
                    begin
                        mode_next = MODE_VBLANK;
                        vbl       = 1'b1;
                        stat      = stat || cfg.stat_irq_enables[EN_VBLANK_BIT];
                    end
                    else
                    begin
                        mode_next = MODE_SCAN;
                        stat      = stat || cfg.stat_irq_enables[EN_SCAN_BIT];
                    end
                end
            end
            default:
            begin
                if (sum >= LINE_LEN)
                begin
                    acc_next = mod_line(sum);
                    // wrap to the top of the frame after the last vblank line
                    if (line_reg >= LAST_LINE)
                    begin
                        line_next = '0;
                        mode_next = MODE_SCAN;
                        stat      = cfg.stat_irq_enables[EN_SCAN_BIT];
                    end
                    else
                    begin
                        line_next = line_reg + 8'd1;
                    end
                    coin_next = (line_next == cfg.compare_line);
                    stat = stat || (coin_next && cfg.stat_irq_enables[EN_COMPARE_BIT]);
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_SCAN;
            acc_reg  <= '0;
            line_reg <= '0;
            coin_reg <= 1'b0;
        end
        else if (step)
        begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
            line_reg <= line_next;
            coin_reg <= coin_next;
        end
    end

    always_comb
    begin
        result.mode_now          = mode_next;
        result.line_now          = line_next;
        result.coincidence       = coin_next;
        result.stat_irq          = stat;
        result.vblank_irq        = vbl;
        result.render_line       = render;
        result.render_line_index = render_idx;
    end
endmodule

@@ design/lcd_scanline_mode_timer_core.sv @@
// LCD scanline mode timer. Each item on in_ch carries the clock cycles elapsed since the
// previous one; the block steps its mode sequencer (object scan, drawing, hblank, vblank
// lines) by at most one transition and returns one item on out_ch with the new mode, line,
// compare flag, interrupt pulses and render request. One item is accepted every clock while
// out_ch takes results; the item passes through the input register and the result register
// that surround the combinational step logic. The result register frees itself in the same
// cycle it is taken, so a stall on out_ch backs up through at most those two registers.
// Configuration writes (compare_line at index 0, stat_irq_enables at index 1) act on the
// next item that is stepped and belong to idle periods.
module lcd_scanline_mode_timer_core (
    input  logic                             clk,
    input  logic                             rst_n,
    lsmt_in_if.sink                          in_ch,
    lsmt_out_if.source                       out_ch,
    input  logic                             cfg_we,
    input  logic [lsmt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lsmt_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import lsmt_pkg::*;

    cfg_t             cfg;
    logic             in_valid_reg;
    logic [CYC_W-1:0] in_cycles_reg;
    logic             out_valid_reg;
    result_t          out_reg;
    result_t          step_result;
    logic             advance;
    logic             step;

    // move the held item into the result register when that register is free
    assign advance = !out_valid_reg || out_ch.ready;
    assign step    = in_valid_reg && advance;
    assign in_ch.ready = !in_valid_reg || advance;

    lsmt_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lsmt_seq u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (step),
        .elapsed_cycles (in_cycles_reg),
        .cfg            (cfg),
        .result         (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ch.ready)
            begin
                in_valid_reg <= in_ch.valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            in_cycles_reg <= in_ch.elapsed_cycles;
        end
        if (step)
        begin
            out_reg <= step_result;
        end
    end

    assign out_ch.valid             = out_valid_reg;
    assign out_ch.mode_now          = out_reg.mode_now;
    assign out_ch.line_now          = out_reg.line_now;
    assign out_ch.coincidence       = out_reg.coincidence;
    assign out_ch.stat_irq          = out_reg.stat_irq;
    assign out_ch.vblank_irq        = out_reg.vblank_irq;
    assign out_ch.render_line       = out_reg.render_line;
    assign out_ch.render_line_index = out_reg.render_line_index;
endmodule

@@ tb/lsmt_frame_checker.sv @@
`timescale 1ns / 1ps

module lsmt_frame_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    lsmt_in_if                              in_ch,
    lsmt_out_if                             out_ch,
    input  logic                            cfg_we,
    input  logic [lsmt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lsmt_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              errors,
    output int                              n_done,
    output int                              pending
);
    import lsmt_pkg::*;

    // Shadow of the configuration registers
    logic [LINE_W-1:0] cmp_line_cfg;
    logic [EN_W-1:0]   irq_mask;

    // Shadow of the sequencer state
    mode_t             frame_mode;
    logic [ACC_W-1:0]  dot_acc;
    logic [LINE_W-1:0] scan_line;
    logic              line_match;

    result_t           timing_q[$];
    int                n_predicted;

    assign pending = n_predicted - n_done;

    // Re-evaluate the compare flag; return the compare pulse request.
    function automatic logic refresh_match();
        line_match = (scan_line == cmp_line_cfg);
        return line_match & irq_mask[EN_COMPARE_BIT];
    endfunction

    function automatic result_t advance_timing(input logic [CYC_W-1:0] cyc);
        result_t r;
        logic    stat;
        r    = '0;
        stat = 1'b0;
        dot_acc = dot_acc + ACC_W'(cyc);
        case (frame_mode)
            MODE_SCAN:
            begin
                if (dot_acc >= SCAN_LEN)
                begin
                    dot_acc    = dot_acc % SCAN_LEN;
                    stat       = refresh_match();
                    frame_mode = MODE_DRAW;
                end
            end
            MODE_DRAW:
            begin
                if (dot_acc >= DRAW_LEN)
                begin
                    dot_acc             = dot_acc - DRAW_LEN;
                    r.render_line       = 1'b1;
                    r.render_line_index = scan_line;
                    frame_mode          = MODE_HBLANK;
                    stat                = irq_mask[EN_HBLANK_BIT];
                end
            end
            MODE_HBLANK:
            begin
                if (dot_acc >= HBLANK_LEN)
                begin
                    dot_acc   = dot_acc % HBLANK_LEN;
                    scan_line = scan_line + 8'd1;
                    stat      = refresh_match();
                    if (scan_line == FIRST_VBLANK_LINE)
                    begin
                        frame_mode   = MODE_VBLANK;
                        r.vblank_irq = 1'b1;
                        stat         = stat | irq_mask[EN_VBLANK_BIT];
                    end
                    else
                    begin
                        frame_mode = MODE_SCAN;
                        stat       = stat | irq_mask[EN_SCAN_BIT];
                    end
                end
            end
            default:
            begin
                if (dot_acc >= LINE_LEN)
                begin
                    dot_acc = dot_acc % LINE_LEN;
                    // wrap to the top of the frame after the last vblank line
                    if (scan_line >= LAST_LINE)
                    begin
                        scan_line  = '0;
                        frame_mode = MODE_SCAN;
                        stat       = irq_mask[EN_SCAN_BIT];
                    end
                    else
                    begin
                        scan_line = scan_line + 8'd1;
                    end
                    stat = stat | refresh_match();
                end
            end
        endcase
        r.mode_now    = frame_mode;
        r.line_now    = scan_line;
        r.coincidence = line_match;
        r.stat_irq    = stat;
        return r;
    endfunction

    function automatic void check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            errors++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            cmp_line_cfg = '0;
            irq_mask     = '0;
            frame_mode   = MODE_SCAN;
            dot_acc      = '0;
            scan_line    = '0;
            line_match   = 1'b0;
            timing_q.delete();
            n_predicted  = 0;
            n_done       = 0;
            errors       = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_IDX_COMPARE_LINE)
                begin
                    cmp_line_cfg = cfg_data[LINE_W-1:0];
                end
                else if (cfg_index == CFG_IDX_STAT_ENABLES)
                begin
                    irq_mask = cfg_data[EN_W-1:0];
                end
            end
            if (in_ch.valid && in_ch.ready)
            begin
                timing_q.push_back(advance_timing(in_ch.elapsed_cycles));
                n_predicted++;
            end
            if (out_ch.valid && out_ch.ready)
            begin
                if (timing_q.size() == 0)
                begin
                    $error("result item with no expectation waiting");
                    errors++;
                end
                else
                begin
                    want = timing_q.pop_front();
                    check_field("mode_now", want.mode_now, out_ch.mode_now);
                    check_field("line_now", want.line_now, out_ch.line_now);
                    check_field("coincidence", want.coincidence, out_ch.coincidence);
                    check_field("stat_irq", want.stat_irq, out_ch.stat_irq);
                    check_field("vblank_irq", want.vblank_irq, out_ch.vblank_irq);
                    check_field("render_line", want.render_line, out_ch.render_line);
                    check_field("render_line_index", want.render_line_index,
                                out_ch.render_line_index);
                end
                n_done++;
            end
        end
    end

endmodule

@@ tb/lcd_scanline_mode_timer_core_tb.sv @@
`timescale 1ns / 1ps

module lcd_scanline_mode_timer_core_tb;
    import lsmt_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_CYCLES = 80;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int errors;
    int n_done;
    int pending;
    int n_sent;
    int cycle_cnt;
    bit quiet;

    lsmt_in_if  in_ch();
    lsmt_out_if out_ch();

    lcd_scanline_mode_timer_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    lsmt_frame_checker i_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .n_done    (n_done),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("[lcd_scanline_mode_timer_core] ERROR");
        $finish;
    end

    // Result side: random stall bursts plus one long hold-off to back up the pipe.
    initial
    begin
        bit held_off;
        held_off = 1'b0;
        out_ch.ready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (!quiet && !held_off && n_sent >= 400)
            begin
                held_off = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
            else
            begin
                out_ch.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    task automatic push_elapsed(input logic [CYC_W-1:0] cyc);
        in_ch.valid          <= 1'b1;
        in_ch.elapsed_cycles <= cyc;
        do @(posedge clk); while (!in_ch.ready);
        n_sent++;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
    endtask

    // Drop valid and let every outstanding item drain before touching the registers.
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (n_done != n_sent);
    endtask

    task automatic write_regs(input logic [LINE_W-1:0] cmp_line, input logic [EN_W-1:0] en);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_IDX_COMPARE_LINE;
        cfg_data  <= CFG_DATA_W'(cmp_line);
        @(posedge clk);
        cfg_index <= CFG_IDX_STAT_ENABLES;
        cfg_data  <= CFG_DATA_W'(en);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [CYC_W-1:0] pick_elapsed();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
        begin
            return '0;
        end
        else if (sel == 1)
        begin
            return '1;
        end
        return CYC_W'($urandom_range(0, 255));
    endfunction

    initial
    begin
        logic [CYC_W-1:0] walk[20];
        logic [LINE_W-1:0] ph_cmp[6];
        logic [EN_W-1:0]   ph_en[6];
        int                ph_len[6];

        // exact boundaries of each mode, then overshoot with full-scale steps
        walk = '{8'd0, 8'd79, 8'd1, 8'd171, 8'd1, 8'd203, 8'd1, 8'd255, 8'd255, 8'd255,
                 8'd0, 8'd0, 8'd0, 8'd128, 8'd255, 8'd64, 8'd255, 8'd255, 8'd170, 8'd1};
        ph_cmp = '{8'd144, 8'd153, 8'd255, 8'd0, 8'd77, 8'd143};
        ph_en  = '{4'b1111, 4'b0101, 4'b0000, 4'b1010, 4'b0001, 4'b1111};
        ph_len = '{300, 300, 250, 300, 300, 300};

        quiet  = 1'b0;
        n_sent = 0;
        rst_n  = 1'b0;
        in_ch.valid          <= 1'b0;
        in_ch.elapsed_cycles <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_regs(8'd0, 4'b1111);
        foreach (walk[i])
        begin
            push_elapsed(walk[i]);
        end
        drain_results();

        for (int p = 0; p < 6; p++)
        begin
            write_regs(ph_cmp[p], ph_en[p]);
            // last stretch runs with no idling on either side
            if (p == 5)
            begin
                quiet = 1'b1;
            end
            for (int k = 0; k < ph_len[p]; k++)
            begin
                push_elapsed(pick_elapsed());
            end
            drain_results();
        end

        repeat (8) @(posedge clk);
        if (errors == 0 && pending == 0)
        begin
            $display("[lcd_scanline_mode_timer_core] OK");
        end
        else
        begin
            $display("[lcd_scanline_mode_timer_core] ERROR");
        end
        $finish;
    end

endmodule
